@@ rtl/fixed_point_q24_8_alu_top_assert.svh @@
// Assertion macros shared by the ALU checker.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define FXA_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("%m: check failed");

// Condition must never be seen outside reset.
`define FXA_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

@@ rtl/fxa_pkg.sv @@
// Types and operation codes for the Q24.8 fixed-point ALU.
package fxa_pkg;

    typedef enum logic [3:0] {
        FUNC_ADD      = 4'd0,
        FUNC_SUB      = 4'd1,
        FUNC_MUL      = 4'd2,
        FUNC_DIV      = 4'd3,
        FUNC_INC      = 4'd4,
        FUNC_DEC      = 4'd5,
        FUNC_MIN      = 4'd6,
        FUNC_MAX      = 4'd7,
        FUNC_GT       = 4'd8,
        FUNC_LT       = 4'd9,
        FUNC_GE       = 4'd10,
        FUNC_LE       = 4'd11,
        FUNC_EQ       = 4'd12,
        FUNC_NE       = 4'd13,
        FUNC_FROM_INT = 4'd14,
        FUNC_TO_INT   = 4'd15
    } func_t;

    localparam int DATA_W = 32;

    // Per-request side information that rides along the divider chain.
    typedef struct packed {
        logic              is_mul;
        logic              is_div;
        logic              neg;
        logic              flag;
        logic              div_error;
        logic [DATA_W-1:0] res;
    } ctl_t;

endpackage

@@ rtl/fxa_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per request.
module fxa_div_cell
    import fxa_pkg::*;
#(
    parameter int NUM_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  ctl_t              ctl_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DATA_W-1:0] den_in,
    input  logic [DATA_W-1:0] rem_in,
    input  logic [NUM_W-1:0]  quot_in,
    output logic              valid_out,
    output ctl_t              ctl_out,
    output logic [NUM_W-1:0]  num_out,
    output logic [DATA_W-1:0] den_out,
    output logic [DATA_W-1:0] rem_out,
    output logic [NUM_W-1:0]  quot_out
);

    logic              valid_reg;
    ctl_t              ctl_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DATA_W-1:0] den_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [NUM_W-1:0]  quot_reg;

    logic [DATA_W-1:0] rem_shift;
    logic              q_bit;
    logic [DATA_W-1:0] rem_next;

    // Remainder stays below the divisor, so its top bit is always clear.
    always_comb begin
        rem_shift = {rem_in[DATA_W-2:0], num_in[NUM_W-1]};
        q_bit     = (rem_shift >= den_in);
        rem_next  = q_bit ? (rem_shift - den_in) : rem_shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg  <= ctl_in;
            num_reg  <= {num_in[NUM_W-2:0], 1'b0};
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            quot_reg <= {quot_in[NUM_W-2:0], q_bit};
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign num_out   = num_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign quot_out  = quot_reg;

endmodule

@@ rtl/fixed_point_q24_8_alu_top.sv @@
// Top level of the signed fixed-point ALU with a cell-chain divider.
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits. One request is
// taken per clock and one response leaves per clock while the output is not
// stalled; every operation takes the same path from acceptance to the output
// register, through the divider: a chain of 32 + FRAC_BITS restoring-division
// cells, one quotient bit each, behind an operand register, a multiply stage
// and a rounding stage. Multiply and divide round to nearest, ties away from
// zero, and wrap to 32 bits. A stalled output freezes the whole pipeline.
module fixed_point_q24_8_alu_top
    import fxa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]  s_tuser,   // [3:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic [1:0]  m_tuser    // [0] flag, [1] div_error
);

    localparam int NQ = DATA_W + FRAC_BITS;

    logic en;

    // Operand register
    logic                     valid1_reg;
    func_t                    func1_reg;
    logic signed [DATA_W-1:0] a1_reg;
    logic signed [DATA_W-1:0] b1_reg;

    // Multiply / decode stage
    logic              valid2_reg;
    ctl_t              ctl2_reg;
    logic [2*DATA_W-1:0] prod2_reg;
    logic [NQ-1:0]     num2_reg;
    logic [DATA_W-1:0] den2_reg;
    ctl_t              ctl2_next;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    // Rounding stage, head of the cell chain
    logic              valid3_reg;
    ctl_t              ctl3_reg;
    logic [NQ-1:0]     num3_reg;
    logic [DATA_W-1:0] den3_reg;
    ctl_t              ctl3_next;
    logic [DATA_W-1:0] mround;

    // Cell chain links
    logic              ch_valid [NQ+1];
    ctl_t              ch_ctl   [NQ+1];
    logic [NQ-1:0]     ch_num   [NQ+1];
    logic [DATA_W-1:0] ch_den   [NQ+1];
    logic [DATA_W-1:0] ch_rem   [NQ+1];
    logic [NQ-1:0]     ch_quot  [NQ+1];

    // Output register
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_res_reg;
    logic              m_flag_reg;
    logic              m_derr_reg;
    logic [DATA_W-1:0] res_next;
    logic              round_up;
    logic [DATA_W-1:0] q_round;
    ctl_t              tail;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg  <= 1'b0;
            valid2_reg  <= 1'b0;
            valid3_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid1_reg  <= s_tvalid;
            valid2_reg  <= valid1_reg;
            valid3_reg  <= valid2_reg;
            m_valid_reg <= ch_valid[NQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg <= func_t'(s_tuser);
            a1_reg    <= s_tdata[31:0];
            b1_reg    <= s_tdata[63:32];
        end
    end

    always_comb begin
        mag_a = a1_reg[DATA_W-1] ? (DATA_W'(0) - a1_reg) : a1_reg;
        mag_b = b1_reg[DATA_W-1] ? (DATA_W'(0) - b1_reg) : b1_reg;
        ctl2_next           = '0;
        ctl2_next.neg       = a1_reg[DATA_W-1] ^ b1_reg[DATA_W-1];
        case (func1_reg)
            FUNC_ADD:      ctl2_next.res = a1_reg + b1_reg;
            FUNC_SUB:      ctl2_next.res = a1_reg - b1_reg;
            FUNC_MUL:      ctl2_next.is_mul = 1'b1;
            FUNC_DIV: begin
                if (b1_reg == '0) begin
                    ctl2_next.div_error = 1'b1;
                end else begin
                    ctl2_next.is_div = 1'b1;
                end
            end
            FUNC_INC:      ctl2_next.res = a1_reg + DATA_W'(1);
            FUNC_DEC:      ctl2_next.res = a1_reg - DATA_W'(1);
            FUNC_MIN:      ctl2_next.res = (a1_reg > b1_reg) ? b1_reg : a1_reg;
            FUNC_MAX:      ctl2_next.res = (a1_reg < b1_reg) ? b1_reg : a1_reg;
            FUNC_GT:       ctl2_next.flag = (a1_reg > b1_reg);
            FUNC_LT:       ctl2_next.flag = (a1_reg < b1_reg);
            FUNC_GE:       ctl2_next.flag = (a1_reg >= b1_reg);
            FUNC_LE:       ctl2_next.flag = (a1_reg <= b1_reg);
            FUNC_EQ:       ctl2_next.flag = (a1_reg == b1_reg);
            FUNC_NE:       ctl2_next.flag = (a1_reg != b1_reg);
            FUNC_FROM_INT: ctl2_next.res = a1_reg <<< FRAC_BITS;
            FUNC_TO_INT:   ctl2_next.res = a1_reg >>> FRAC_BITS;
            default:       ctl2_next.res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl2_reg  <= ctl2_next;
            prod2_reg <= {{DATA_W{1'b0}}, mag_a} * {{DATA_W{1'b0}}, mag_b};
            num2_reg  <= NQ'(mag_a) << FRAC_BITS;
            den2_reg  <= mag_b;
        end
    end

    // Round the product to nearest, ties away from zero, then apply the sign.
    always_comb begin
        mround    = prod2_reg[FRAC_BITS +: DATA_W] + DATA_W'(prod2_reg[FRAC_BITS-1]);
        ctl3_next = ctl2_reg;
        if (ctl2_reg.is_mul) begin
            ctl3_next.res = ctl2_reg.neg ? (DATA_W'(0) - mround) : mround;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl3_reg <= ctl3_next;
            num3_reg <= num2_reg;
            den3_reg <= den2_reg;
        end
    end

    assign ch_valid[0] = valid3_reg;
    assign ch_ctl[0]   = ctl3_reg;
    assign ch_num[0]   = num3_reg;
    assign ch_den[0]   = den3_reg;
    assign ch_rem[0]   = '0;
    assign ch_quot[0]  = '0;

    for (genvar i = 0; i < NQ; i++) begin : g_cell
        fxa_div_cell #(
            .NUM_W(NQ)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (ch_valid[i]),
            .ctl_in    (ch_ctl[i]),
            .num_in    (ch_num[i]),
            .den_in    (ch_den[i]),
            .rem_in    (ch_rem[i]),
            .quot_in   (ch_quot[i]),
            .valid_out (ch_valid[i+1]),
            .ctl_out   (ch_ctl[i+1]),
            .num_out   (ch_num[i+1]),
            .den_out   (ch_den[i+1]),
            .rem_out   (ch_rem[i+1]),
            .quot_out  (ch_quot[i+1])
        );
    end

    // Round the quotient: bump when twice the remainder reaches the divisor.
    always_comb begin
        tail     = ch_ctl[NQ];
        round_up = ({ch_rem[NQ], 1'b0} >= {1'b0, ch_den[NQ]});
        q_round  = ch_quot[NQ][DATA_W-1:0] + DATA_W'(round_up);
        if (tail.is_div) begin
            res_next = tail.neg ? (DATA_W'(0) - q_round) : q_round;
        end else begin
            res_next = tail.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg  <= res_next;
            m_flag_reg <= tail.flag;
            m_derr_reg <= tail.div_error;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg;
    assign m_tuser  = {m_derr_reg, m_flag_reg};

endmodule

@@ rtl/fxa_checker.sv @@
// Port-level checker for the fixed-point ALU, bound to the top level.
`include "fixed_point_q24_8_alu_top_assert.svh"

module fxa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `FXA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `FXA_ASSERT(a_derr_zero, m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
    `FXA_NEVER(a_flag_and_derr, m_tvalid && m_tuser[0] && m_tuser[1])
    `FXA_ASSERT(a_stall_cause, !s_tready |-> m_tvalid && !m_tready)

endmodule

bind fixed_point_q24_8_alu_top fxa_checker u_fxa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb.sv @@
// Testbench for the signed fixed-point ALU: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
    import fxa_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 35;
    localparam int RANDOM_REQS = 1250;

    typedef struct {
        logic [31:0] result;
        logic        flag;
        logic        div_error;
    } alu_out_t;

    class alu_scoreboard;
        alu_out_t pending[$];
        int errors = 0;

        function automatic logic [31:0] round_mul(logic signed [31:0] a, logic signed [31:0] b);
            logic [63:0] p;
            logic [63:0] q;
            logic [63:0] ma;
            logic [63:0] mb;
            ma = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
            mb = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
            p = ma * mb;
            q = p >> FRAC;
            if (p[FRAC-1]) q = q + 1;
            if (a[31] != b[31]) q = -q;
            return q[31:0];
        endfunction

        function automatic logic [31:0] round_div(logic signed [31:0] a, logic signed [31:0] b);
            logic [63:0] n;
            logic [63:0] d;
            logic [63:0] q;
            logic [63:0] r;
            n = (a[31] ? 64'(-64'(signed'(a))) : 64'(a)) << FRAC;
            d = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
            q = n / d;
            r = n % d;
            if (2 * r >= d) q = q + 1;
            if (a[31] != b[31]) q = -q;
            return q[31:0];
        endfunction

        function void note_request(func_t f, logic signed [31:0] a, logic signed [31:0] b);
            alu_out_t o;
            o.result = '0;
            o.flag = 1'b0;
            o.div_error = 1'b0;
            case (f)
                FUNC_ADD: o.result = a + b;
                FUNC_SUB: o.result = a - b;
                FUNC_MUL: o.result = round_mul(a, b);
                FUNC_DIV: begin
                    if (b == 0) o.div_error = 1'b1;
                    else o.result = round_div(a, b);
                end
                FUNC_INC: o.result = a + 1;
                FUNC_DEC: o.result = a - 1;
                FUNC_MIN: o.result = (a > b) ? b : a;
                FUNC_MAX: o.result = (a < b) ? b : a;
                FUNC_GT: o.flag = a > b;
                FUNC_LT: o.flag = a < b;
                FUNC_GE: o.flag = a >= b;
                FUNC_LE: o.flag = a <= b;
                FUNC_EQ: o.flag = a == b;
                FUNC_NE: o.flag = a != b;
                FUNC_FROM_INT: o.result = a <<< FRAC;
                FUNC_TO_INT: o.result = a >>> FRAC;
                default: o.result = '0;
            endcase
            pending.push_back(o);
        endfunction

        function void check_result(logic [31:0] res, logic [1:0] user);
            alu_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected response: result %h user %b", res, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.result) begin
                $error("result: expected %h, actual %h", e.result, res);
                errors++;
            end
            if (user[0] !== e.flag) begin
                $error("flag: expected %b, actual %b", e.flag, user[0]);
                errors++;
            end
            if (user[1] !== e.div_error) begin
                $error("div_error: expected %b, actual %b", e.div_error, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    alu_scoreboard board = new();
    bit idle_off = 1'b0;
    bit stim_done = 1'b0;

    fixed_point_q24_8_alu_top #(.FRAC_BITS(FRAC)) dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // sample responses at the rising edge, pick the next stall at the falling edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // present one request and hold it until accepted; leaves valid high
    task automatic send_request(func_t f, logic [31:0] a, logic [31:0] b);
        int gap;
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(f, a, b);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] half_step;
        half_step = {16'h0, 8'($urandom_range(0, 255)), 8'h80};
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 1024) - 512;
            3: return ($urandom_range(0, 1) != 0) ? (32'd0 - half_step) : half_step;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        func_t f;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(FUNC_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_request(FUNC_SUB, 32'h8000_0000, 32'h0000_0001);
        send_request(FUNC_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(FUNC_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        send_request(FUNC_MUL, 32'h0000_0001, 32'h0000_0080);
        send_request(FUNC_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        send_request(FUNC_DIV, 32'h0000_0100, 32'h0000_0000);
        send_request(FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_DIV, 32'h0000_0001, 32'h0000_0200);
        send_request(FUNC_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
        send_request(FUNC_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_DEC, 32'h8000_0000, 32'h1234_5678);
        send_request(FUNC_MIN, 32'h0000_0005, 32'h0000_0005);
        send_request(FUNC_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_GT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_LT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_GE, 32'h0000_0101, 32'h0000_0101);
        send_request(FUNC_LE, 32'h0000_0101, 32'h0000_01FF);
        send_request(FUNC_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_NE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(FUNC_FROM_INT, 32'h00FF_FFFF, 32'h0);
        send_request(FUNC_FROM_INT, 32'hFF80_0001, 32'h0);
        send_request(FUNC_TO_INT, 32'hFFFF_FF01, 32'h0);
        send_request(FUNC_TO_INT, 32'h7FFF_FFFF, 32'h0);

        // hold off until the pipeline has drained
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == RANDOM_REQS - 150) idle_off = 1'b1;
            f = func_t'($urandom_range(0, 15));
            a = random_operand();
            b = ($urandom_range(0, 9) == 0) ? 32'h0 : random_operand();
            send_request(f, a, b);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
